### rtl/edm_pkg.sv
// edm_pkg: shared types and constants for the euclidean distance matrix block
// field widths, state encoding and the pipeline tag carried with each distance
// no dependencies
package edm_pkg;

    // fixed field widths
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int ROOT_W    = 17;
    localparam int SUM_W     = 2 * ROOT_W;
    localparam int DIST_W    = ROOT_W;
    localparam int IDX_OUT_W = 6;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_ISSUE
    } edm_state_t;

    // control fields that travel alongside each distance
    typedef struct packed {
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
        logic                 last;
        logic                 ovf;
    } edm_tag_t;

endpackage

### rtl/euclidean_distance_matrix.sv
// euclidean_distance_matrix: one row of pairwise distances per arriving point
// path: store read, square, sum, root stages, output register; s_ready low while issuing
// throughput: a point with n stored before it issues n+1 distances (one on overflow),
//   one per cycle unless m_ready stalls, limited by the single read port of the point store
// reset: sequencer idle, point count zero, pipeline emptied; the store is not cleared
// depends on edm_pkg and edm_isqrt
module euclidean_distance_matrix #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [edm_pkg::COORD_W-1:0]  s_point_x,
    input  logic signed [edm_pkg::COORD_W-1:0]  s_point_y,
    input  logic                                s_first_point,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [edm_pkg::IDX_OUT_W-1:0]       m_row_index,
    output logic [edm_pkg::IDX_OUT_W-1:0]       m_column_index,
    output logic [edm_pkg::DIST_W-1:0]          m_distance,
    output logic                                m_last_in_row,
    output logic                                m_overflow
);
    import edm_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // sequencer and point registers
    edm_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next, count_eff;
    logic [IDX_W-1:0]           row_reg, row_next;
    logic [IDX_W-1:0]           col_reg, col_next;
    logic                       ovf_reg, ovf_next;
    logic signed [COORD_W-1:0]  px_reg, px_next;
    logic signed [COORD_W-1:0]  py_reg, py_next;
    logic                       en, issue, wr_en;

    // point store
    logic signed [COORD_W-1:0]  mem_x_reg [MAX_POINTS];
    logic signed [COORD_W-1:0]  mem_y_reg [MAX_POINTS];
    logic signed [COORD_W-1:0]  rd_x_reg, rd_y_reg;

    // pipeline
    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    edm_tag_t                   s1_tag_reg, s2_tag_reg, s3_tag_reg, issue_tag;
    logic signed [COORD_W-1:0]  s1_px_reg, s1_py_reg;
    logic signed [DIFF_W-1:0]   dx, dy;
    logic [COORD_W-1:0]         adx, ady;
    logic [SQ_W-1:0]            sq_x_reg, sq_y_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic                       rt_valid;
    edm_tag_t                   rt_tag;
    logic [ROOT_W-1:0]          rt_root;

    // output register
    logic                       m_valid_reg;
    edm_tag_t                   m_tag_reg;
    logic [DIST_W-1:0]          m_dist_reg;

    // whole pipeline advances whenever the output slot is free or being taken
    assign en = !m_valid_reg || m_ready;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        ovf_next   = ovf_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        wr_en      = 1'b0;
        count_eff  = s_first_point ? '0 : count_reg;
        s_ready    = (state_reg == ST_IDLE);
        issue      = en && (state_reg == ST_ISSUE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ISSUE;
                    col_next   = '0;
                    px_next    = s_point_x;
                    py_next    = s_point_y;
                    if (count_eff >= CNT_W'(MAX_POINTS)) begin
                        ovf_next   = 1'b1;
                        count_next = count_eff;
                    end else begin
                        ovf_next   = 1'b0;
                        wr_en      = 1'b1;
                        row_next   = count_eff[IDX_W-1:0];
                        count_next = count_eff + 1'b1;
                    end
                end
            end
            ST_ISSUE: begin
                if (en) begin
                    if (ovf_reg || col_reg == row_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // current point and indices
    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        col_reg <= col_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
    end

    // store write on a request unless the store is full, registered read while issuing
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x_reg[count_eff[IDX_W-1:0]] <= s_point_x;
            mem_y_reg[count_eff[IDX_W-1:0]] <= s_point_y;
        end
        if (issue) begin
            rd_x_reg <= mem_x_reg[col_reg];
            rd_y_reg <= mem_y_reg[col_reg];
        end
    end

    // tag for the distance being issued
    always_comb begin
        issue_tag.row  = ovf_reg ? '0 : IDX_OUT_W'(row_reg);
        issue_tag.col  = ovf_reg ? '0 : IDX_OUT_W'(col_reg);
        issue_tag.last = !ovf_reg && (col_reg == row_reg);
        issue_tag.ovf  = ovf_reg;
    end

    // differences and magnitudes
    always_comb begin
        dx  = DIFF_W'(s1_px_reg) - DIFF_W'(rd_x_reg);
        dy  = DIFF_W'(s1_py_reg) - DIFF_W'(rd_y_reg);
        adx = dx[DIFF_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
        ady = dy[DIFF_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            m_valid_reg  <= rt_valid;
        end
    end

    // pipeline payload: stage-one tag and point, square, sum, and output
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tag_reg <= issue_tag;
            s1_px_reg  <= px_reg;
            s1_py_reg  <= py_reg;
            sq_x_reg   <= SQ_W'(adx) * SQ_W'(adx);
            sq_y_reg   <= SQ_W'(ady) * SQ_W'(ady);
            s2_tag_reg <= s1_tag_reg;
            sum_reg    <= SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg);
            s3_tag_reg <= s2_tag_reg;
            m_tag_reg  <= rt_tag;
            m_dist_reg <= rt_tag.ovf ? '0 : rt_root;
        end
    end

    edm_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_tag    (s3_tag_reg),
        .in_rad    (sum_reg),
        .out_valid (rt_valid),
        .out_tag   (rt_tag),
        .out_root  (rt_root)
    );

    assign m_valid        = m_valid_reg;
    assign m_row_index    = m_tag_reg.row;
    assign m_column_index = m_tag_reg.col;
    assign m_distance     = m_dist_reg;
    assign m_last_in_row  = m_tag_reg.last;
    assign m_overflow     = m_tag_reg.ovf;

`ifndef ASSERT_OFF
    // a taken request always starts an issue pass
    a_accept_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_ISSUE)
        else $error("request taken without issue pass");

    // point count stays within the store
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    // column never passes the row while issuing distances
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ISSUE && !ovf_reg |-> col_reg <= row_reg)
        else $error("column index passed row index");

    // an overflow result carries no distance and no row end
    a_ovf_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_distance == '0 && !m_last_in_row)
        else $error("overflow result carries data");

    // the result at a row end belongs to the diagonal, so it is zero
    a_diag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_in_row |-> m_distance == '0 && m_row_index == m_column_index)
        else $error("row end is not a zero diagonal distance");
`endif

endmodule

### rtl/edm_isqrt.sv
// edm_isqrt: pipelined floor square root, one root bit per stage
// radicand SUM_W bits, root ROOT_W bits, tag passed along unchanged
// depends on edm_pkg
module edm_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  edm_pkg::edm_tag_t             in_tag,
    input  logic [edm_pkg::SUM_W-1:0]     in_rad,
    output logic                          out_valid,
    output edm_pkg::edm_tag_t             out_tag,
    output logic [edm_pkg::ROOT_W-1:0]    out_root
);
    import edm_pkg::*;

    localparam int REM_W = ROOT_W + 1;
    localparam int TRY_W = REM_W + 2;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SUM_W-1:0]  rad_reg  [ROOT_W];
    logic              valid_reg [ROOT_W];
    edm_tag_t          tag_reg  [ROOT_W];

    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [SUM_W-1:0]  rad_next  [ROOT_W];

    // one restoring step per stage: bring down two radicand bits, try 4q+1
    always_comb begin
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  rad_in;
        logic [TRY_W-1:0]  trial;
        logic [TRY_W-1:0]  tv;
        logic [TRY_W-1:0]  diff;
        rem_in  = '0;
        root_in = '0;
        rad_in  = in_rad;
        for (int k = 0; k < ROOT_W; k++) begin
            trial = {rem_in, rad_in[SUM_W-1 -: 2]};
            tv    = TRY_W'({root_in, 2'b01});
            diff  = trial - tv;
            if (trial >= tv) begin
                rem_next[k]  = diff[REM_W-1:0];
                root_next[k] = {root_in[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = trial[REM_W-1:0];
                root_next[k] = {root_in[ROOT_W-2:0], 1'b0};
            end
            rad_next[k] = rad_in << 2;
            // the following stage starts from this stage's registers
            rem_in  = rem_reg[k];
            root_in = root_reg[k];
            rad_in  = rad_reg[k];
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ROOT_W; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < ROOT_W; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            for (int k = 0; k < ROOT_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
            for (int k = 1; k < ROOT_W; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule
